FILE: hdl/assert_macros.svh
// Assertion macros for the speed sync RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define FWSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define FWSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/fwss_pkg.sv
// Types, widths and codes shared by the four-wheel speed sync block.
package fwss_pkg;

    localparam int CNT_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int FILT_W     = CNT_W + FRAC_W;
    localparam int NW         = 4;
    localparam int NW_W       = $clog2(NW + 1);
    localparam int WHEEL_W    = $clog2(NW);
    localparam int SUM_W      = FILT_W + $clog2(NW);
    localparam int DUTY_W     = 10;
    localparam int GAIN_W     = 4;
    localparam int MBIT_W     = $clog2(GAIN_W);
    localparam int DB_W       = 8;
    localparam int WARM_W     = 8;
    localparam int THR_W      = 16;
    localparam int DIR_W      = 4;
    localparam int MODE_W     = 2;
    localparam int IN_CNT_W   = 16;
    localparam int PROD_W     = FILT_W + GAIN_W;
    localparam int CORR_W     = PROD_W - FRAC_W;
    localparam int TGT_W      = ((CORR_W > DUTY_W + 1) ? CORR_W : DUTY_W + 1) + 2;
    localparam int CMP_W      = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam int DIV_STEP_W = $clog2(SUM_W + 1);

    localparam int S_DATA_W   = 80;
    localparam int M_DATA_W   = 48;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FWD = 2'd1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DUTY_FLOOR,
        CFG_DUTY_CEILING,
        CFG_PROP_GAIN,
        CFG_ERROR_DEADBAND,
        CFG_STALL_KICK,
        CFG_WARMUP_TICKS,
        CFG_MOVING_THRESHOLD,
        CFG_FORWARD_PATTERN
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_WARM,
        ST_SUM,
        ST_DSTART,
        ST_DIV,
        ST_ERR,
        ST_MUL,
        ST_TGT,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: hdl/four_wheel_speed_sync_core.sv
// Top level of the four-wheel speed sync controller.
`include "assert_macros.svh"

// Four-wheel speed sync. One input item is one control tick: drive mode
// (s_tuser) plus a base duty and four wrapping hall counts (s_tdata). A tick
// with mode off is taken and changes nothing. An active tick updates the
// per-wheel deltas and half-step filters, then, once warmup is over and at
// least one wheel moved, averages the moving filters, applies deadband,
// proportional gain and stall kick, clamps and sends one result item with
// four duties and the direction mask. The block takes one tick at a time.
// An active tick runs the delta/filter pass (one wheel a cycle); when it
// ends in warmup or with no moving wheel it stops there. Otherwise it sums
// the moving filters, runs the bit-serial divider (one quotient bit per
// cycle over the 26-bit sum), then per wheel the error, a shift-add gain
// multiply over the four gain bits and the clamp. The result sits in an
// output register; the next tick is taken while it waits, and the block
// stalls only if a second result is ready before the first is taken.
// Config writes are accepted every cycle (cfg_ready is always high) and
// should only be made while no tick is in flight.
module four_wheel_speed_sync_core
    import fwss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input ticks
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [9:0] cmd_duty, [25:10] count_fl, [41:26] count_fr,
    // [57:42] count_bl, [73:58] count_br, [79:74] zero
    input  logic [S_DATA_W-1:0]   s_tdata,
    // [1:0] mode
    input  logic [MODE_W-1:0]     s_tuser,
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [9:0] duty_fl, [19:10] duty_fr, [29:20] duty_bl,
    // [39:30] duty_br, [43:40] dir_mask, [47:44] zero
    output logic [M_DATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int BASE_LSB = 0;
    localparam int CNT_LSB  = DUTY_W;

    // configuration
    logic [DUTY_W-1:0] cfg_floor_reg, cfg_floor_next;
    logic [DUTY_W-1:0] cfg_ceil_reg, cfg_ceil_next;
    logic [GAIN_W-1:0] cfg_gain_reg, cfg_gain_next;
    logic [DB_W-1:0]   cfg_db_reg, cfg_db_next;
    logic [DUTY_W-1:0] cfg_kick_reg, cfg_kick_next;
    logic [WARM_W-1:0] cfg_warm_reg, cfg_warm_next;
    logic [THR_W-1:0]  cfg_thr_reg, cfg_thr_next;
    logic [DIR_W-1:0]  cfg_fwd_reg, cfg_fwd_next;

    // control
    state_t             state_reg, state_next;
    logic [WHEEL_W-1:0] wheel_reg, wheel_next;
    logic [MBIT_W-1:0]  mbit_reg, mbit_next;
    logic [WARM_W-1:0]  warm_done_reg, warm_done_next;
    logic               out_valid_reg, out_valid_next;

    // persistent wheel state, kept as rotating rings: entry 0 is the wheel
    // being worked on, it re-enters at the top after its step
    logic [CNT_W-1:0]   prev_reg [NW];
    logic [CNT_W-1:0]   prev_next [NW];
    logic [FILT_W-1:0]  filt_reg [NW];
    logic [FILT_W-1:0]  filt_next [NW];

    // tick working data
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [DUTY_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]   cnt_reg [NW];
    logic [CNT_W-1:0]   cnt_next [NW];
    logic [NW-1:0]      zero_reg, zero_next;
    logic [NW-1:0]      move_reg, move_next;
    logic [NW_W-1:0]    n_reg, n_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [FILT_W-1:0]  mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [DUTY_W-1:0]  duty_reg [NW];
    logic [DUTY_W-1:0]  duty_next [NW];
    logic [M_DATA_W-1:0] out_reg, out_next;

    // combinational helpers
    logic               accept_active;
    logic               last_wheel;
    logic               warm_active;
    logic [NW_W-1:0]    moving_cnt;
    logic               out_free;
    logic               out_load;
    logic               div_start;
    logic [SUM_W-1:0]   quotient;
    div_stat_t          div_stat;
    logic [FILT_W-1:0]  avg;
    logic [CNT_W-1:0]   delta;
    logic [FILT_W:0]    filt_sum;
    logic [FILT_W-1:0]  err_mag;
    logic               err_neg;
    logic [CORR_W-1:0]  corr;
    logic signed [TGT_W-1:0] corr_s;
    logic signed [TGT_W-1:0] tgt;
    logic signed [TGT_W-1:0] tgt_c;
    logic [DIR_W-1:0]   dir;

    assign cfg_ready     = 1'b1;
    assign accept_active = s_tvalid && (s_tuser != MODE_OFF);
    assign last_wheel    = wheel_reg == WHEEL_W'(NW - 1);
    assign warm_active   = warm_done_reg < cfg_warm_reg;
    assign moving_cnt    = NW_W'($countones(move_reg));
    assign out_free      = !out_valid_reg || m_tready;
    assign out_load      = (state_reg == ST_WRITE) && out_free;
    assign avg           = quotient[FILT_W-1:0];

    // ------------------------------------------------------------ divider
    fwss_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (n_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // ------------------------------------------------------- config port
    always_comb
    begin
        cfg_floor_next = cfg_floor_reg;
        cfg_ceil_next  = cfg_ceil_reg;
        cfg_gain_next  = cfg_gain_reg;
        cfg_db_next    = cfg_db_reg;
        cfg_kick_next  = cfg_kick_reg;
        cfg_warm_next  = cfg_warm_reg;
        cfg_thr_next   = cfg_thr_reg;
        cfg_fwd_next   = cfg_fwd_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_DUTY_FLOOR:       cfg_floor_next = cfg_data[DUTY_W-1:0];
                CFG_DUTY_CEILING:     cfg_ceil_next  = cfg_data[DUTY_W-1:0];
                CFG_PROP_GAIN:        cfg_gain_next  = cfg_data[GAIN_W-1:0];
                CFG_ERROR_DEADBAND:   cfg_db_next    = cfg_data[DB_W-1:0];
                CFG_STALL_KICK:       cfg_kick_next  = cfg_data[DUTY_W-1:0];
                CFG_WARMUP_TICKS:     cfg_warm_next  = cfg_data[WARM_W-1:0];
                CFG_MOVING_THRESHOLD: cfg_thr_next   = cfg_data[THR_W-1:0];
                CFG_FORWARD_PATTERN:  cfg_fwd_next   = cfg_data[DIR_W-1:0];
            endcase
        end
    end

    // -------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_active)
                    state_next = ST_DELTA;
            end
            ST_DELTA:
            begin
                if (last_wheel)
                    state_next = ST_WARM;
            end
            ST_WARM:
            begin
                if (warm_active || (moving_cnt == '0))
                    state_next = ST_IDLE;
                else
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (last_wheel)
                    state_next = ST_DSTART;
            end
            ST_DSTART:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_ERR;
            end
            ST_ERR:
                state_next = ST_MUL;
            ST_MUL:
            begin
                if (mbit_reg == '0)
                    state_next = ST_TGT;
            end
            ST_TGT:
                state_next = last_wheel ? ST_WRITE : ST_ERR;
            ST_WRITE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ----------------------------------------------------- state outputs
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready  = 1'b1;
            ST_DSTART: div_start = 1'b1;
            default:
            begin
                s_tready  = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------- datapath
    // delta and half-step filter for the wheel at the head of the ring
    assign delta    = cnt_reg[0] - prev_reg[0];
    assign filt_sum = {1'b0, delta, {FRAC_W{1'b0}}} + {1'b0, filt_reg[0]};

    // error against the average; neg means the wheel runs fast
    assign err_neg = avg < filt_reg[0];
    assign err_mag = err_neg ? (filt_reg[0] - avg) : (avg - filt_reg[0]);

    // gain product back to whole pulses, sign restored after truncation
    assign corr   = prod_reg[PROD_W-1:FRAC_W];
    assign corr_s = neg_reg ? -TGT_W'(corr) : TGT_W'(corr);
    assign tgt    = TGT_W'(base_reg) + corr_s
                  + (zero_reg[0] ? TGT_W'(cfg_kick_reg) : TGT_W'(0));

    // ceiling first, then floor, so a floor above the ceiling wins;
    // signed compares so a negative target lands on the floor
    always_comb
    begin
        tgt_c = tgt;
        if (tgt_c > $signed(TGT_W'(cfg_ceil_reg)))
            tgt_c = TGT_W'(cfg_ceil_reg);
        if (tgt_c < $signed(TGT_W'(cfg_floor_reg)))
            tgt_c = TGT_W'(cfg_floor_reg);
    end

    // mode three falls in with reverse
    assign dir = (mode_reg == MODE_FWD) ? cfg_fwd_reg : ~cfg_fwd_reg;

    always_comb
    begin
        wheel_next     = wheel_reg;
        mbit_next      = mbit_reg;
        warm_done_next = warm_done_reg;
        prev_next      = prev_reg;
        filt_next      = filt_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        base_next      = base_reg;
        zero_next      = zero_reg;
        move_next      = move_reg;
        n_next         = n_reg;
        sum_next       = sum_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        duty_next      = duty_reg;
        out_next       = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_active)
                begin
                    mode_next = s_tuser;
                    base_next = s_tdata[BASE_LSB +: DUTY_W];
                    for (int i = 0; i < NW; i++)
                        cnt_next[i] = s_tdata[CNT_LSB + i*IN_CNT_W +: CNT_W];
                    wheel_next = '0;
                end
            end
            ST_DELTA:
            begin
                for (int i = 0; i < NW - 1; i++)
                begin
                    prev_next[i] = prev_reg[i+1];
                    filt_next[i] = filt_reg[i+1];
                    cnt_next[i]  = cnt_reg[i+1];
                end
                prev_next[NW-1] = cnt_reg[0];
                filt_next[NW-1] = filt_sum[FILT_W:1];
                cnt_next[NW-1]  = cnt_reg[0];
                zero_next = {(delta == '0), zero_reg[NW-1:1]};
                move_next = {(CMP_W'(delta) >= CMP_W'(cfg_thr_reg)), move_reg[NW-1:1]};
                wheel_next = wheel_reg + 1'b1;
            end
            ST_WARM:
            begin
                // warmup counter stops at the limit, so lowering it ends warmup
                if (warm_active)
                    warm_done_next = warm_done_reg + 1'b1;
                n_next     = moving_cnt;
                sum_next   = '0;
                wheel_next = '0;
            end
            ST_SUM:
            begin
                if (move_reg[0])
                    sum_next = sum_reg + SUM_W'(filt_reg[0]);
                for (int i = 0; i < NW - 1; i++)
                    filt_next[i] = filt_reg[i+1];
                filt_next[NW-1] = filt_reg[0];
                move_next  = {move_reg[0], move_reg[NW-1:1]};
                wheel_next = wheel_reg + 1'b1;
            end
            ST_DSTART:
                wheel_next = '0;
            ST_DIV:
                wheel_next = '0;
            ST_ERR:
            begin
                if (err_mag < (FILT_W'(cfg_db_reg) << FRAC_W))
                    mag_next = '0;
                else
                    mag_next = err_mag;
                neg_next  = err_neg;
                prod_next = '0;
                mbit_next = MBIT_W'(GAIN_W - 1);
            end
            ST_MUL:
            begin
                // MSB-first shift-add over the gain bits
                prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                          + (cfg_gain_reg[mbit_reg] ? PROD_W'(mag_reg) : PROD_W'(0));
                mbit_next = mbit_reg - 1'b1;
            end
            ST_TGT:
            begin
                for (int i = 0; i < NW - 1; i++)
                begin
                    filt_next[i] = filt_reg[i+1];
                    duty_next[i] = duty_reg[i+1];
                end
                filt_next[NW-1] = filt_reg[0];
                duty_next[NW-1] = tgt_c[DUTY_W-1:0];
                zero_next  = {zero_reg[0], zero_reg[NW-1:1]};
                wheel_next = wheel_reg + 1'b1;
            end
            ST_WRITE:
            begin
                if (out_free)
                    out_next = M_DATA_W'({dir, duty_reg[3], duty_reg[2],
                                          duty_reg[1], duty_reg[0]});
            end
            default:
                wheel_next = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // ---------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wheel_reg     <= '0;
            mbit_reg      <= '0;
            warm_done_reg <= '0;
            out_valid_reg <= 1'b0;
            cfg_floor_reg <= DUTY_W'(350);
            cfg_ceil_reg  <= DUTY_W'(1023);
            cfg_gain_reg  <= GAIN_W'(3);
            cfg_db_reg    <= DB_W'(1);
            cfg_kick_reg  <= DUTY_W'(150);
            cfg_warm_reg  <= WARM_W'(5);
            cfg_thr_reg   <= THR_W'(1);
            cfg_fwd_reg   <= DIR_W'(5);
            for (int i = 0; i < NW; i++)
            begin
                prev_reg[i] <= '0;
                filt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            wheel_reg     <= wheel_next;
            mbit_reg      <= mbit_next;
            warm_done_reg <= warm_done_next;
            out_valid_reg <= out_valid_next;
            cfg_floor_reg <= cfg_floor_next;
            cfg_ceil_reg  <= cfg_ceil_next;
            cfg_gain_reg  <= cfg_gain_next;
            cfg_db_reg    <= cfg_db_next;
            cfg_kick_reg  <= cfg_kick_next;
            cfg_warm_reg  <= cfg_warm_next;
            cfg_thr_reg   <= cfg_thr_next;
            cfg_fwd_reg   <= cfg_fwd_next;
            prev_reg      <= prev_next;
            filt_reg      <= filt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        mode_reg <= mode_next;
        base_reg <= base_next;
        zero_reg <= zero_next;
        move_reg <= move_next;
        n_reg    <= n_next;
        sum_reg  <= sum_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        duty_reg <= duty_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // --------------------------------------------------------- assertions
    `FWSS_ASSERT(a_div_start_idle, div_start |-> !div_stat.busy && (n_reg != '0),
                 "divider started while busy or with no moving wheel")
    `FWSS_ASSERT(a_div_done_state, div_stat.done |-> state_reg == ST_DIV,
                 "divider finished outside the divide wait")
    `FWSS_ASSERT(a_result_source, $rose(m_tvalid) |-> $past(state_reg) == ST_WRITE,
                 "result appeared without a write step")
    `FWSS_ASSERT(a_no_accept_busy, (state_reg != ST_IDLE) |-> !s_tready,
                 "tick accepted while another is in flight")
    `FWSS_ASSERT_ALWAYS(a_reset_idle,
                        !rst_n |-> (state_reg == ST_IDLE) && !out_valid_reg,
                        "control state not cleared in reset")

endmodule

FILE: hdl/fwss_div.sv
// Bit-serial restoring divider: wheel filter sum over the count of moving wheels.
module fwss_div
    import fwss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [NW_W-1:0]   divisor,
    output logic [SUM_W-1:0]  quotient,
    output div_stat_t         stat
);

    logic [SUM_W-1:0]      q_reg, q_next;
    logic [NW_W-1:0]       rem_reg, rem_next;
    logic [DIV_STEP_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [NW_W:0]         trial;
    logic                  fits;

    // one quotient bit per cycle, dividend bits shift out the top of q_reg
    assign trial = {rem_reg, q_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = DIV_STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[SUM_W-2:0], fits};
            rem_next = fits ? NW_W'(trial - {1'b0, divisor}) : trial[NW_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: sim/speed_sync_checker.sv
// Checker for the four-wheel speed sync core: predicts result items and compares them.
module speed_sync_checker
    import fwss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [MODE_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending,
    output int                    ticks_seen,
    output int                    results_seen
);

    // Same layout as m_tdata, lowest field last.
    typedef struct packed {
        logic [3:0]                pad;
        logic [DIR_W-1:0]          dir_mask;
        logic [NW-1:0][DUTY_W-1:0] duty;
    } drive_cmd_t;

    localparam string WHEEL_NAME [NW] = '{"fl", "fr", "bl", "br"};

    // register copy
    logic [DUTY_W-1:0] duty_lo;
    logic [DUTY_W-1:0] duty_hi;
    logic [GAIN_W-1:0] gain;
    logic [DB_W-1:0]   deadband;
    logic [DUTY_W-1:0] kick;
    logic [WARM_W-1:0] warm_len;
    logic [THR_W-1:0]  move_min;
    logic [DIR_W-1:0]  fwd_dirs;

    // wheel state
    logic [CNT_W-1:0]  last_cnt [NW];
    logic [FILT_W-1:0] speed    [NW];
    logic [WARM_W-1:0] warm_cnt;

    drive_cmd_t drive_q [$];
    int         faults = 0;
    int         ticks  = 0;
    int         results = 0;

    initial
    begin
        mismatches   = 0;
        pending      = 0;
        ticks_seen   = 0;
        results_seen = 0;
    end

    task automatic report(input string what, input logic [M_DATA_W-1:0] want_v,
                          input logic [M_DATA_W-1:0] got_v);
        faults++;
        if (faults <= 10)
            $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what,
                     want_v, got_v);
    endtask

    // One control tick; returns 1 when it produces a result.
    function automatic bit sync_tick(input logic [MODE_W-1:0] mode,
                                     input logic [S_DATA_W-1:0] data,
                                     output drive_cmd_t cmd);
        logic [CNT_W-1:0]    delta [NW];
        logic [CNT_W-1:0]    now;
        logic [FILT_W:0]     half_sum;
        logic [SUM_W-1:0]    sum;
        logic [SUM_W-1:0]    avg;
        logic [NW_W-1:0]     moving;
        logic [FILT_W-1:0]   mag;
        logic [PROD_W-1:0]   prod;
        logic [CORR_W-1:0]   corr;
        logic                neg;
        int                  target;
        cmd = '0;
        if (mode == MODE_OFF)
            return 1'b0;
        for (int w = 0; w < NW; w++)
        begin
            now         = data[DUTY_W + CNT_W*w +: CNT_W];
            delta[w]    = now - last_cnt[w];
            last_cnt[w] = now;
            half_sum    = {1'b0, delta[w], {FRAC_W{1'b0}}} + {1'b0, speed[w]};
            speed[w]    = half_sum[FILT_W:1];
        end
        if (warm_cnt < warm_len)
        begin
            warm_cnt = warm_cnt + 1'b1;
            return 1'b0;
        end
        sum    = '0;
        moving = '0;
        for (int w = 0; w < NW; w++)
        begin
            if (delta[w] >= move_min)
            begin
                sum    = sum + SUM_W'(speed[w]);
                moving = moving + 1'b1;
            end
        end
        if (moving == 0)
            return 1'b0;
        avg = sum / SUM_W'(moving);
        for (int w = 0; w < NW; w++)
        begin
            neg = avg < SUM_W'(speed[w]);
            mag = neg ? FILT_W'(SUM_W'(speed[w]) - avg) : FILT_W'(avg - SUM_W'(speed[w]));
            if (mag < FILT_W'({deadband, {FRAC_W{1'b0}}}))
                mag = '0;
            prod   = PROD_W'(mag) * PROD_W'(gain);
            corr   = prod[PROD_W-1:FRAC_W];
            target = int'(data[DUTY_W-1:0]);
            if (neg)
                target = target - int'(corr);
            else
                target = target + int'(corr);
            if (delta[w] == 0)
                target = target + int'(kick);
            if (target > int'(duty_hi))
                target = int'(duty_hi);
            if (target < int'(duty_lo))
                target = int'(duty_lo);
            cmd.duty[w] = target[DUTY_W-1:0];
        end
        cmd.dir_mask = (mode == MODE_FWD) ? fwd_dirs : ~fwd_dirs;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        drive_cmd_t want;
        drive_cmd_t got;
        if (!rst_n)
        begin
            duty_lo  = 10'd350;
            duty_hi  = 10'd1023;
            gain     = 4'd3;
            deadband = 8'd1;
            kick     = 10'd150;
            warm_len = 8'd5;
            move_min = 16'd1;
            fwd_dirs = 4'd5;
            for (int w = 0; w < NW; w++)
            begin
                last_cnt[w] = '0;
                speed[w]    = '0;
            end
            warm_cnt = '0;
            drive_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_addr))
                    CFG_DUTY_FLOOR:       duty_lo  = cfg_data[DUTY_W-1:0];
                    CFG_DUTY_CEILING:     duty_hi  = cfg_data[DUTY_W-1:0];
                    CFG_PROP_GAIN:        gain     = cfg_data[GAIN_W-1:0];
                    CFG_ERROR_DEADBAND:   deadband = cfg_data[DB_W-1:0];
                    CFG_STALL_KICK:       kick     = cfg_data[DUTY_W-1:0];
                    CFG_WARMUP_TICKS:     warm_len = cfg_data[WARM_W-1:0];
                    CFG_MOVING_THRESHOLD: move_min = cfg_data[THR_W-1:0];
                    CFG_FORWARD_PATTERN:  fwd_dirs = cfg_data[DIR_W-1:0];
                    default: ;
                endcase
            end
            // results first, so a result never meets the tick taken at the same edge
            if (m_tvalid && m_tready)
            begin
                got = drive_cmd_t'(m_tdata);
                results++;
                if (drive_q.size() == 0)
                    report("unexpected result, data", '0, m_tdata);
                else
                begin
                    want = drive_q.pop_front();
                    for (int w = 0; w < NW; w++)
                        if (got.duty[w] !== want.duty[w])
                            report({"duty_", WHEEL_NAME[w]}, M_DATA_W'(want.duty[w]),
                                   M_DATA_W'(got.duty[w]));
                    if (got.dir_mask !== want.dir_mask)
                        report("dir_mask", M_DATA_W'(want.dir_mask),
                               M_DATA_W'(got.dir_mask));
                    if (got.pad !== want.pad)
                        report("pad bits", M_DATA_W'(want.pad), M_DATA_W'(got.pad));
                end
            end
            if (s_tvalid && s_tready)
            begin
                ticks++;
                if (sync_tick(s_tuser, s_tdata, want))
                    drive_q.push_back(want);
            end
        end
        pending      <= drive_q.size();
        mismatches   <= faults;
        ticks_seen   <= ticks;
        results_seen <= results;
    end

endmodule

FILE: sim/four_wheel_speed_sync_core_test.sv
// Testbench top for the four-wheel speed sync core: stimulus, pacing and verdict.
module four_wheel_speed_sync_core_test;
    import fwss_pkg::*;

    // Reverse drive; mode three also drives the reverse pattern.
    localparam logic [MODE_W-1:0] MODE_REV = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALT = 2'd3;

    localparam int CYCLE_LIMIT = 600000;
    // Settling time after the last result, longer than a full tick with a result.
    localparam int SETTLE      = 100;
    localparam int HOLD_CYCLES = 400;

    logic                  clk       = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [MODE_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;
    int ticks_seen;
    int results_seen;

    bit quiet    = 1'b0;   // no gaps and no stalls on either side
    bit hold_req = 1'b0;   // asks the result side for one long hold-off
    int cycle_count = 0;
    int active_sent = 0;
    int settings_run = 1;  // reset values count as the first setting

    // Cumulative hall counts and per-wheel pace of the simulated car.
    logic [CNT_W-1:0] odo  [NW];
    int               pace [NW];

    four_wheel_speed_sync_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    speed_sync_checker scoreboard
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .ticks_seen   (ticks_seen),
        .results_seen (results_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending);
            $display("four_wheel_speed_sync_core_test: done, errors");
            $finish;
        end
    end

    // Result side. Holds m_tready low for a random stall before each item, or once for HOLD_CYCLES so
    // the block fills its output register and backs up the tick input.
    initial
    begin : result_sink
        int stall;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = quiet ? 0 : int'($urandom_range(5));
            if (hold_req)
            begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Offers one tick with the current counts; returns at the accepting edge
    // with s_tvalid still high, so back-to-back ticks never toggle it.
    task automatic send_tick(input logic [MODE_W-1:0] mode, input logic [DUTY_W-1:0] base);
        int gap;
        gap = quiet ? 0 : int'($urandom_range(5));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'b0, odo[3], odo[2], odo[1], odo[0], base};
        if (mode != MODE_OFF)
            active_sent++;
        do @(posedge clk); while (!s_tready);
    endtask

    // Directed tick: moves each wheel by the given steps (negative runs back).
    task automatic nudge(input logic [MODE_W-1:0] mode, input logic [DUTY_W-1:0] base,
                         input int fl, input int fr, input int bl, input int br);
        odo[0] = odo[0] + CNT_W'(fl);
        odo[1] = odo[1] + CNT_W'(fr);
        odo[2] = odo[2] + CNT_W'(bl);
        odo[3] = odo[3] + CNT_W'(br);
        send_tick(mode, base);
    endtask

    // Sender pause: no tick until every expected result is in, then let a
    // tick that gives no result finish inside the block.
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Block must be idle: caller drains first.
    task automatic load_setting(input int unsigned lo, input int unsigned hi,
                                input int unsigned gain, input int unsigned db,
                                input int unsigned kick, input int unsigned warm,
                                input int unsigned thr, input int unsigned dirs);
        write_reg(CFG_DUTY_FLOOR, lo);
        write_reg(CFG_DUTY_CEILING, hi);
        write_reg(CFG_PROP_GAIN, gain);
        write_reg(CFG_ERROR_DEADBAND, db);
        write_reg(CFG_STALL_KICK, kick);
        write_reg(CFG_WARMUP_TICKS, warm);
        write_reg(CFG_MOVING_THRESHOLD, thr);
        write_reg(CFG_FORWARD_PATTERN, dirs);
        settings_run++;
    endtask

    // Ordinary operating point: low floor, high ceiling, small deadband.
    task automatic load_random_setting(input int unsigned warm);
        load_setting($urandom_range(400), $urandom_range(1023, 600), $urandom_range(15),
                     $urandom_range(6), $urandom_range(300), warm, $urandom_range(30),
                     $urandom_range(15));
    endtask

    // One random tick. Mostly steady driving at a per-wheel pace with some
    // stalled wheels, the rest jumps, single-step reversals (delta of all
    // ones), fast spins and pure noise on the counts.
    task automatic random_tick;
        int               pick;
        int               w;
        logic [MODE_W-1:0] mode;
        pick = $urandom_range(99);
        if (pick < 8)
            mode = MODE_OFF;
        else if (pick < 50)
            mode = MODE_FWD;
        else if (pick < 88)
            mode = MODE_REV;
        else
            mode = MODE_ALT;
        pick = $urandom_range(99);
        w    = $urandom_range(NW - 1);
        if (pick < 72)
        begin
            if ($urandom_range(15) == 0)
                for (int k = 0; k < NW; k++)
                    pace[k] = $urandom_range(60);
            for (int k = 0; k < NW; k++)
                if ($urandom_range(9) != 0)
                    odo[k] = odo[k] + CNT_W'(pace[k] + int'($urandom_range(6)));
        end
        else if (pick < 82)
            odo[w] = CNT_W'($urandom);
        else if (pick < 87)
            odo[w] = odo[w] - 1'b1;
        else if (pick < 92)
        begin
            for (int k = 0; k < NW; k++)
                odo[k] = odo[k] + CNT_W'($urandom_range(65535));
        end
        else
        begin
            for (int k = 0; k < NW; k++)
                odo[k] = CNT_W'($urandom);
        end
        send_tick(mode, DUTY_W'($urandom_range(1023)));
    endtask

    // Runs until n more ticks with an active mode have gone in.
    task automatic run_random(input int n);
        int goal;
        goal = active_sent + n;
        while (active_sent < goal)
            random_tick();
    endtask

    initial
    begin : stimulus
        rst_n <= 1'b0;
        for (int k = 0; k < NW; k++)
        begin
            odo[k]  = '0;
            pace[k] = 20;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks at reset settings (warmup of five ticks).
        odo[0] = 16'hFFFF; odo[1] = 16'hFFFF; odo[2] = 16'hFFFF; odo[3] = 16'hFFFF;
        send_tick(MODE_FWD, 10'd0);                     // all-ones counts
        nudge(MODE_REV, 10'd1023, 20, 20, 20, 20);      // counts wrap through zero
        nudge(MODE_FWD, 10'd1023, 20, 20, 20, 20);
        nudge(MODE_ALT, 10'd300, 20, 20, 20, 20);
        nudge(MODE_FWD, 10'd300, 20, 20, 20, 20);       // last warmup tick
        nudge(MODE_FWD, 10'd512, 20, 20, 20, 20);       // first result, equal speeds
        nudge(MODE_REV, 10'd512, 10, 20, 30, 40);
        nudge(MODE_ALT, 10'd600, 30, 30, 30, 0);        // stalled wheel gets the kick
        odo[1] = CNT_W'($urandom);
        nudge(MODE_OFF, 10'd1023, 0, 0, 0, 0);          // ignored entirely
        nudge(MODE_FWD, 10'd700, 0, 0, 0, 0);           // only fr moved, by a random jump
        nudge(MODE_FWD, 10'd1023, 5, 5, 5, 5);
        nudge(MODE_FWD, 10'd0, -1, 5, 5, 5);            // count ran back: huge delta
        nudge(MODE_REV, 10'd0, 3000, 0, 1, 40000);
        nudge(MODE_FWD, 10'd1023, 1, 0, 0, 0);
        for (int k = 0; k < NW; k++)
            odo[k] = 16'h0000;
        send_tick(MODE_REV, 10'd345);
        run_random(200);
        drain();

        // Extremes one way: every wheel moving, no deadband, full gain and kick,
        // no warmup.
        load_setting(0, 1023, 15, 0, 1023, 0, 0, 15);
        run_random(100);
        drain();
        run_random(100);
        drain();

        // Extremes the other way: floor above ceiling, widest deadband, zero
        // gain and kick, only a one-step reversal counts as moving.
        load_setting(1023, 0, 0, 255, 0, 0, 65535, 0);
        run_random(60);
        drain();

        // Long warmup, then shortened: warmup ends at once.
        load_random_setting(255);
        run_random(100);
        drain();
        load_random_setting(3);
        hold_req = 1'b1;
        run_random(250);
        drain();

        // A stretch with no gaps on either side, then normal pacing.
        load_random_setting($urandom_range(8));
        quiet = 1'b1;
        run_random(80);
        quiet = 1'b0;
        run_random(150);
        drain();

        repeat (2)
        begin
            load_random_setting($urandom_range(8));
            run_random(230);
            drain();
        end

        $display("ran %0d ticks (%0d active) under %0d register settings, %0d results checked",
                 ticks_seen, active_sent, settings_run, results_seen);
        $display("covered wrap and run-back counts, stalls, floor above ceiling, "
                 , "zero threshold, warmup cut short and a %0d-cycle output hold", HOLD_CYCLES);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("four_wheel_speed_sync_core_test: done, clean");
        else
            $display("four_wheel_speed_sync_core_test: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/fwss_pkg.sv
hdl/fwss_div.sv
hdl/four_wheel_speed_sync_core.sv
sim/speed_sync_checker.sv
sim/four_wheel_speed_sync_core_test.sv
